/* sv/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CGR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("property check failed");
`define CGR_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define CGR_ASSERT(lbl, clk, rst_n, prop)
`define CGR_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* sv/cgr_pkg.sv */
package cgr_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [16:0] Q16_ONE            = 17'h10000;
  localparam logic [31:0] NOT_COVERED_COLOUR = 32'h0000_00FF;
  localparam logic [12:0] RAMP_WIDTH_RESET   = 13'd256;

  // register index 0 lives below byte address 4
  localparam logic [2:0] REG_RAMP_WIDTH_END = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [16:0] pos;
    logic [31:0] colour;
    logic [11:0] pixel;
  } cmd_t;

  typedef struct packed {
    logic [31:0] colour;
    logic        covered;
    logic        accepted;
  } res_t;

  typedef struct packed {
    logic       busy;
    logic [6:0] stop_count;
  } status_t;

endpackage

/* sv/cgr_front.sv */
module cgr_front (
  input  logic [1:0]    opcode_i,
  input  logic [16:0]   stop_position_i,
  input  logic [31:0]   stop_colour_i,
  input  logic [11:0]   pixel_index_i,
  output cgr_pkg::cmd_t cmd_o
);

  always_comb begin
    cmd_o.opcode = opcode_i;
    // positions above one clamp to one
    cmd_o.pos    = (stop_position_i > cgr_pkg::Q16_ONE) ? cgr_pkg::Q16_ONE : stop_position_i;
    cmd_o.colour = stop_colour_i;
    cmd_o.pixel  = pixel_index_i;
  end

endmodule

/* sv/cgr_fifo.sv */
module cgr_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] buf_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = buf_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wp_q <= !wp_q;
      end
      if (do_pop) begin
        rp_q <= !rp_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wp_q] <= data_i;
    end
  end

endmodule

/* sv/cgr_back.sv */
module cgr_back #(
  parameter int MAX_STOPS = 16,
  parameter int MAX_WIDTH = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [12:0]      ramp_width_i,
  input  logic             cmd_valid_i,
  input  cgr_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  output cgr_pkg::res_t    res_o,
  output logic             res_valid_o,
  input  logic             res_pop_i,
  output cgr_pkg::status_t st_o
);

  localparam int AW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int CW = $clog2(MAX_STOPS + 1);
  localparam logic [12:0] WidthCap = (MAX_WIDTH > 8191) ? 13'h1FFF : 13'(MAX_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_CMP, S_INS_PUT, S_Q_FIRST, S_Q_LEN, S_Q_CMP,
    S_DIV_MUL, S_DIV, S_DIV_FIN, S_OUT
  } state_e;

  state_e        state_q;
  logic [CW-1:0] count_q, k_q;
  logic [AW-1:0] i_q;
  cgr_pkg::cmd_t cmd_q;
  logic [48:0]   rd_q, prev_q, cur_q;
  logic [29:0]   prod_q;
  logic [14:0]   off_q;
  logic [13:0]   len_q, j_q;
  logic [21:0]   num_q [4];
  logic [7:0]    quo_q [4];
  logic [3:0]    neg_q;
  logic [2:0]    bit_q;
  cgr_pkg::res_t res_q, ores_q;
  logic          ovalid_q;

  // stop table: position in the top 17 bits, colour below
  logic [48:0]   mem [MAX_STOPS];

  logic [AW-1:0] ra, wa;
  logic          we;
  logic [48:0]   wd;
  logic          ins_gt;
  logic [12:0]   width_eff;
  logic [16:0]   diff;
  logic [13:0]   seg_len;
  logic [15:0]   seg_end;
  logic          hit;
  logic [14:0]   pix_rel;
  logic [7:0]    lane_a [4];
  logic [7:0]    lane_b [4];
  logic [3:0]    lane_neg;
  logic [7:0]    lane_mag [4];
  logic [31:0]   fin_colour;
  logic [21:0]   trial;
  logic          out_load;

  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i;
  assign res_o       = ores_q;
  assign res_valid_o = ovalid_q;
  assign st_o.busy   = (state_q != S_IDLE);
  assign st_o.stop_count = 7'(count_q);

  // result register takes a new result when free or popped this cycle
  assign out_load  = (state_q == S_OUT) && (!ovalid_q || res_pop_i);

  assign width_eff = (ramp_width_i > WidthCap) ? WidthCap : ramp_width_i;
  assign ins_gt    = rd_q[48:32] > cmd_q.pos;
  assign diff      = rd_q[48:32] - prev_q[48:32];
  assign seg_len   = prod_q[29:16];
  assign seg_end   = {1'b0, off_q} + {2'b0, seg_len};
  assign hit       = {4'b0, cmd_q.pixel} < seg_end;
  assign pix_rel   = {3'b0, cmd_q.pixel} - off_q;
  assign trial     = 22'(len_q) << bit_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      lane_a[c]   = prev_q[8*c +: 8];
      lane_b[c]   = cur_q[8*c +: 8];
      lane_neg[c] = lane_b[c] < lane_a[c];
      lane_mag[c] = lane_neg[c] ? (lane_a[c] - lane_b[c]) : (lane_b[c] - lane_a[c]);
      fin_colour[8*c +: 8] = neg_q[c] ? (lane_a[c] - quo_q[c]) : (lane_a[c] + quo_q[c]);
    end
  end

  // table port control
  always_comb begin
    ra = '0;
    we = 1'b0;
    wa = k_q[AW-1:0];
    wd = {cmd_q.pos, cmd_q.colour};
    case (state_q)
      S_IDLE: begin
        wd = {cmd_i.pos, cmd_i.colour};
        wa = '0;
        if (cmd_i.opcode == cgr_pkg::OP_INSERT) begin
          ra = AW'(count_q - CW'(1));
          we = cmd_pop_o && (count_q == '0);
        end
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (ins_gt) begin
          wd = rd_q;
          ra = AW'(k_q - CW'(2));
        end
      end
      S_INS_PUT: we = 1'b1;
      S_Q_FIRST: ra = AW'(1);
      S_Q_CMP:   ra = AW'(CW'(i_q) + CW'(2));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (res_pop_i && ovalid_q) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            // uncovered colour for a query, refused insert on a full table
            res_q <= '{colour:   (cmd_i.opcode == cgr_pkg::OP_QUERY) ?
                                 cgr_pkg::NOT_COVERED_COLOUR : 32'h0,
                       covered:  1'b0,
                       accepted: !((cmd_i.opcode == cgr_pkg::OP_INSERT) &&
                                   (count_q == CW'(MAX_STOPS)))};
            case (cmd_i.opcode)
              cgr_pkg::OP_INSERT: begin
                if (count_q == '0) begin
                  count_q <= CW'(1);
                  state_q <= S_OUT;
                end else if (count_q == CW'(MAX_STOPS)) begin
                  state_q <= S_OUT;
                end else begin
                  k_q     <= count_q;
                  state_q <= S_INS_CMP;
                end
              end
              cgr_pkg::OP_CLEAR: begin
                count_q <= '0;
                state_q <= S_OUT;
              end
              cgr_pkg::OP_QUERY: begin
                if (count_q < CW'(2)) begin
                  state_q <= S_OUT;
                end else begin
                  i_q     <= '0;
                  off_q   <= '0;
                  state_q <= S_Q_FIRST;
                end
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_INS_CMP: begin
          if (ins_gt) begin
            k_q <= k_q - CW'(1);
            if (k_q == CW'(1)) begin
              state_q <= S_INS_PUT;
            end
          end else begin
            count_q <= count_q + CW'(1);
            state_q <= S_OUT;
          end
        end
        S_INS_PUT: begin
          count_q <= count_q + CW'(1);
          state_q <= S_OUT;
        end
        S_Q_FIRST: begin
          prev_q  <= rd_q;
          state_q <= S_Q_LEN;
        end
        S_Q_LEN: begin
          cur_q   <= rd_q;
          prod_q  <= 30'(diff) * 30'(width_eff);
          state_q <= S_Q_CMP;
        end
        S_Q_CMP: begin
          if (hit) begin
            len_q   <= seg_len;
            j_q     <= 14'(pix_rel);
            state_q <= S_DIV_MUL;
          end else begin
            off_q <= 15'(seg_end);
            if (CW'(i_q) + CW'(2) < count_q) begin
              i_q     <= i_q + AW'(1);
              prev_q  <= cur_q;
              state_q <= S_Q_LEN;
            end else begin
              res_q.colour <= cgr_pkg::NOT_COVERED_COLOUR;
              state_q      <= S_OUT;
            end
          end
        end
        S_DIV_MUL: begin
          for (int c = 0; c < 4; c++) begin
            num_q[c] <= 22'(lane_mag[c]) * 22'(j_q);
            quo_q[c] <= '0;
          end
          neg_q   <= lane_neg;
          bit_q   <= 3'd7;
          state_q <= S_DIV;
        end
        S_DIV: begin
          // one quotient bit per lane per cycle, quotient fits a byte
          for (int c = 0; c < 4; c++) begin
            if (num_q[c] >= trial) begin
              num_q[c]        <= num_q[c] - trial;
              quo_q[c][bit_q] <= 1'b1;
            end
          end
          if (bit_q == 3'd0) begin
            state_q <= S_DIV_FIN;
          end else begin
            bit_q <= bit_q - 3'd1;
          end
        end
        S_DIV_FIN: begin
          res_q   <= '{colour: fin_colour, covered: 1'b1, accepted: 1'b1};
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            ores_q  <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/color_stop_gradient_ramp_core.sv */
// Colour gradient ramp with up to MAX_STOPS sorted colour stops. Commands go in
// through a queue-style port (push/full) and every command gives exactly one
// result on the pop/empty side. Insert (opcode 0) places a stop after all stops
// of equal position; clear (1) and the unused opcode go straight to the result.
// A query (2) with fewer than two stops is uncovered; otherwise it walks the
// segments through the single read port of the stop table (one multiply, one
// compare), then does the four channel divides (products, 8 quotient bits one
// per cycle, combine). Commands wait in a two-entry queue while the engine
// works, and a finished result sits in its own output register so the next
// command starts before it is popped. ramp_width lives at byte address 0 of
// the apb port, reset 256, clamped to MAX_WIDTH when used. Positions above
// 1.0 clamp to 1.0.
`include "assert_macros.svh"

module color_stop_gradient_ramp_core #(
  parameter int MAX_STOPS = 16,
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [16:0] stop_position_i,
  input  logic [31:0] stop_colour_i,
  input  logic [11:0] pixel_index_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [31:0] pixel_colour_o,
  output logic        covered_o,
  output logic        accepted_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0]      width_q;
  logic             reg_sel;
  cgr_pkg::cmd_t    cmd_in, q_cmd;
  logic             q_valid, q_pop;
  cgr_pkg::res_t    res;
  logic             res_valid;
  cgr_pkg::status_t st;
  logic             uncov_ok;

  // apb: single register, no wait states
  assign pready  = 1'b1;
  assign reg_sel = paddr < cgr_pkg::REG_RAMP_WIDTH_END;
  assign prdata  = reg_sel ? {19'b0, width_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= cgr_pkg::RAMP_WIDTH_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      width_q <= pwdata[12:0];
    end
  end

  // front: clamp and pack the command
  cgr_front u_front (
    .opcode_i        (opcode_i),
    .stop_position_i (stop_position_i),
    .stop_colour_i   (stop_colour_i),
    .pixel_index_i   (pixel_index_i),
    .cmd_o           (cmd_in)
  );

  // command queue between front and engine
  cgr_fifo #(.W($bits(cgr_pkg::cmd_t))) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_cmd)
  );

  // back: stop table, segment walk, channel divides
  cgr_back #(.MAX_STOPS(MAX_STOPS), .MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ramp_width_i (width_q),
    .cmd_valid_i  (q_valid),
    .cmd_i        (q_cmd),
    .cmd_pop_o    (q_pop),
    .res_o        (res),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop),
    .st_o         (st)
  );

  assign empty          = !res_valid;
  assign pixel_colour_o = res.colour;
  assign covered_o      = res.covered;
  assign accepted_o     = res.accepted;

  // uncovered results carry either zero or opaque black
  assign uncov_ok = covered_o || (pixel_colour_o == 32'h0) ||
                    (pixel_colour_o == cgr_pkg::NOT_COVERED_COLOUR);

  // stop count stays within the table
  `CGR_NEVER(a_count_bound, clk_i, rst_ni, st.stop_count > 7'(MAX_STOPS))
  // a covered pixel can only come from an accepted command
  `CGR_ASSERT(a_cov_acc, clk_i, rst_ni, (!empty && covered_o) |-> accepted_o)
  // an uncovered nonzero colour is always opaque black
  `CGR_ASSERT(a_uncov_black, clk_i, rst_ni, !empty |-> uncov_ok)
  // the engine only starts on a queued command
  `CGR_ASSERT(a_start_queued, clk_i, rst_ni, $rose(st.busy) |-> $past(q_valid))

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_STOPS = 16;
  localparam int MAX_WIDTH = 4096;
  // cycles without any transfer before the run is declared hung
  localparam int HANG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [1:0]  opcode_i;
  logic [16:0] stop_position_i;
  logic [31:0] stop_colour_i;
  logic [11:0] pixel_index_i;
  logic        empty;
  logic        pop;
  logic [31:0] pixel_colour_o;
  logic        covered_o;
  logic        accepted_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  color_stop_gradient_ramp_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode_i),
    .stop_position_i(stop_position_i),
    .stop_colour_i  (stop_colour_i),
    .pixel_index_i  (pixel_index_i),
    .empty          (empty),
    .pop            (pop),
    .pixel_colour_o (pixel_colour_o),
    .covered_o      (covered_o),
    .accepted_o     (accepted_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // shadow copy of the stop table and the ramp width
  logic [16:0] shadow_pos [MAX_STOPS];
  logic [31:0] shadow_col [MAX_STOPS];
  int unsigned shadow_count;
  logic [12:0] shadow_width;

  cgr_pkg::res_t pending_pixels[$];
  int          fail_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_req;      // toggled by the test to start a long pop hold-off
  logic        hold_seen;
  int          hold_left;
  int          quiet_cycles;
  logic [16:0] last_pos;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // one channel: a + trunc((b-a)*j/len) toward zero
  function automatic logic [7:0] blend_channel(logic [7:0] a, logic [7:0] b,
                                              longint unsigned j, longint unsigned len);
    longint unsigned mag;
    if (b >= a) begin
      mag = (longint'(b - a) * j) / len;
      return a + mag[7:0];
    end
    mag = (longint'(a - b) * j) / len;
    return a - mag[7:0];
  endfunction

  // applies one command to the shadow table and returns the expected result
  function automatic cgr_pkg::res_t ramp_predict(logic [1:0] op, logic [16:0] pos,
                                                 logic [31:0] col, logic [11:0] pix);
    cgr_pkg::res_t r;
    int k;
    longint unsigned wid, ofs, diff, len;
    r = '{colour: 32'd0, covered: 1'b0, accepted: 1'b1};
    case (op)
      cgr_pkg::OP_INSERT: begin
        if (shadow_count >= MAX_STOPS) begin
          r.accepted = 1'b0;
        end else begin
          if (pos > cgr_pkg::Q16_ONE) pos = cgr_pkg::Q16_ONE;
          k = shadow_count;
          // equal positions: new stop lands after the existing ones
          while (k > 0 && shadow_pos[k-1] > pos) begin
            shadow_pos[k] = shadow_pos[k-1];
            shadow_col[k] = shadow_col[k-1];
            k--;
          end
          shadow_pos[k] = pos;
          shadow_col[k] = col;
          shadow_count++;
        end
      end
      cgr_pkg::OP_CLEAR: shadow_count = 0;
      cgr_pkg::OP_QUERY: begin
        r.colour = cgr_pkg::NOT_COVERED_COLOUR;
        wid = (shadow_width > MAX_WIDTH) ? MAX_WIDTH : shadow_width;
        ofs = 0;
        if (shadow_count >= 2) begin
          for (int i = 0; i + 1 < shadow_count; i++) begin
            diff = shadow_pos[i+1] - shadow_pos[i];
            len = (diff * wid) >> 16;
            if (pix < ofs + len) begin
              for (int sh = 0; sh < 32; sh += 8)
                r.colour[sh+:8] = blend_channel(shadow_col[i][sh+:8],
                                                shadow_col[i+1][sh+:8], pix - ofs, len);
              r.covered = 1'b1;
              break;
            end
            ofs += len;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // offers one command; push is left high so back-to-back transfers need no toggle
  task automatic send_item(logic [1:0] op, logic [16:0] pos, logic [31:0] col,
                           logic [11:0] pix);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    opcode_i        <= op;
    stop_position_i <= pos;
    stop_colour_i   <= col;
    pixel_index_i   <= pix;
    do @(posedge clk_i); while (full);
    pending_pixels = {pending_pixels, ramp_predict(op, pos, col, pix)};
  endtask

  // stop offering and let every result drain, plus engine slack
  task automatic drain;
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_width(logic [31:0] value);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'd0;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_width = value[12:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed;
    send_item(cgr_pkg::OP_QUERY, 17'd0, 32'd0, 12'd0);              // empty table
    send_item(cgr_pkg::OP_INSERT, 17'd0, 32'hFF00_80FF, 12'd0);
    send_item(cgr_pkg::OP_QUERY, 17'd0, 32'd0, 12'd0);              // only one stop
    send_item(cgr_pkg::OP_INSERT, 17'h1FFFF, 32'h00FF_7F00, 12'd0); // saturates to 1.0
    send_item(cgr_pkg::OP_QUERY, 17'd0, 32'd0, 12'd0);
    send_item(cgr_pkg::OP_QUERY, 17'd0, 32'd0, 12'd128);
    send_item(cgr_pkg::OP_QUERY, 17'd0, 32'd0, 12'd255);
    send_item(cgr_pkg::OP_QUERY, 17'd0, 32'd0, 12'd256);            // past the span
    send_item(cgr_pkg::OP_QUERY, 17'd0, 32'd0, 12'hFFF);
    send_item(cgr_pkg::OP_INSERT, 17'h08000, 32'h1234_5678, 12'd0);
    send_item(cgr_pkg::OP_INSERT, 17'h08000, 32'h8765_4321, 12'd0); // equal position
    send_item(cgr_pkg::OP_QUERY, 17'd0, 32'd0, 12'd127);
    send_item(cgr_pkg::OP_QUERY, 17'd0, 32'd0, 12'd128);
    send_item(OP_UNUSED, 17'h1FFFF, 32'hFFFF_FFFF, 12'hFFF);        // unused opcode
    for (int i = 0; i < 13; i++)                                    // fill, then overflow
      send_item(cgr_pkg::OP_INSERT, 17'($urandom_range(0, 65536)), $urandom, 12'd0);
    send_item(cgr_pkg::OP_QUERY, 17'd0, 32'd0, 12'd200);
    send_item(cgr_pkg::OP_CLEAR, 17'd0, 32'd0, 12'd0);
    send_item(cgr_pkg::OP_QUERY, 17'd0, 32'd0, 12'd0);
  endtask

  task automatic test_random(int n, int sidle, int ridle);
    int r;
    logic [1:0] op;
    logic [16:0] pos;
    logic [11:0] pix;
    int span;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    span = (shadow_width > MAX_WIDTH) ? MAX_WIDTH : shadow_width;
    for (int n_done = 0; n_done < n; n_done++) begin
      r = $urandom_range(0, 99);
      op = (r < 45) ? cgr_pkg::OP_INSERT : (r < 90) ? cgr_pkg::OP_QUERY :
           (r < 97) ? cgr_pkg::OP_CLEAR : OP_UNUSED;
      r = $urandom_range(0, 99);
      if (r < 10) pos = cgr_pkg::Q16_ONE;
      else if (r < 15) pos = 17'($urandom);
      else if (r < 25) pos = last_pos;
      else pos = 17'($urandom_range(0, 65536));
      last_pos = pos;
      pix = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, span > 4095 ? 4095 : span))
                                       : 12'($urandom);
      send_item(op, pos, $urandom, pix);
    end
  endtask

  // the receiver stops popping while commands keep coming, so full must rise
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = ~hold_req;
    for (int i = 0; i < 24; i++)
      send_item((i % 2) ? cgr_pkg::OP_QUERY : cgr_pkg::OP_INSERT,
                17'($urandom_range(0, 65536)), $urandom, 12'($urandom_range(0, 255)));
  endtask

  // pop side: random stalls, a counted hold-off, and the result check
  always @(posedge clk_i) begin
    cgr_pkg::res_t want;
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      pop       <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
    if (rst_ni && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_colour_o !== want.colour) begin
          $error("pixel_colour expected %h actual %h", want.colour, pixel_colour_o);
          fail_count++;
        end
        if (covered_o !== want.covered) begin
          $error("covered expected %b actual %b", want.covered, covered_o);
          fail_count++;
        end
        if (accepted_o !== want.accepted) begin
          $error("accepted expected %b actual %b", want.accepted, accepted_o);
          fail_count++;
        end
      end
    end
  end

  // hang detector: any transfer on either side or the apb port resets it
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || psel || !rst_ni || hold_left > 0)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    push            <= 1'b0;
    opcode_i        <= cgr_pkg::OP_INSERT;
    stop_position_i <= '0;
    stop_colour_i   <= '0;
    pixel_index_i   <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    pop             <= 1'b0;
    hold_req        = 1'b0;
    hold_seen       = 1'b0;
    hold_left       = 0;
    quiet_cycles    = 0;
    fail_count      = 0;
    send_idle_pct   = 33;
    recv_idle_pct   = 68;
    shadow_count    = 0;
    shadow_width    = cgr_pkg::RAMP_WIDTH_RESET;
    last_pos        = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    write_width(32'd1);                 // narrowest nonzero ramp
    test_random(60, 33, 68);
    write_width(32'd4096);              // widest ramp
    test_random(200, 33, 68);
    write_width(32'h1FFF);              // above the maximum, saturates
    test_random(60, 68, 33);
    write_width(32'd0);                 // nothing covered
    test_random(40, 68, 33);
    write_width(32'($urandom_range(2, 4095)));
    test_random(200, 68, 33);
    test_backpressure();
    write_width(32'd256);
    test_random(260, 0, 0);
    drain();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
